@@ src/bale_pkg.sv @@
package bale_pkg;

  // Storage geometry
  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the request and result
  localparam int FUNC_W = 3;
  localparam int WORD_W = 32;
  localparam int IDX_W  = 7;
  localparam int POS_W  = 7;
  localparam int OCNT_W = 8;

  // Width wide enough to compare a request index against the live count
  localparam int WIDE_W = (CNT_W > IDX_W + 1) ? CNT_W : IDX_W + 1;

  // Function codes
  localparam logic [FUNC_W-1:0] FN_CLEAR       = 3'd0;
  localparam logic [FUNC_W-1:0] FN_APPEND      = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP         = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE_AT   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SEARCH      = 3'd4;
  localparam logic [FUNC_W-1:0] FN_FIND_REMOVE = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] value;
    logic [IDX_W-1:0]         index;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [POS_W-1:0]  position;
    logic [OCNT_W-1:0] count;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

@@ src/bounded_array_list_engine_core.sv @@
// Packed list of signed 32-bit words with a live count.
// Request channel: in_valid/in_ready carrying in_req (func, value, index).
// Result channel: out_valid/out_ready carrying out_rsp (status, position, count).
// Exactly one result per request, in request order.
// Clear, append, remove-last and unknown codes finish in the accept cycle, as
// do a remove-at with an out-of-range index and a search of an empty list.
// Search reads the word store once per entry through its registered read
// port. Remove-at-index moves each later word down one slot, one read and
// one write per cycle. Find-and-remove is a search followed by that move
// starting at the match.
// One request is worked on at a time; in_ready is high whenever no request is
// in progress, even while a finished result waits in the output register.
// If out_ready stays low, a finished result is parked until the output
// register frees, and no new request is taken meanwhile.
// Reset (rst_n low, synchronous) empties the list; the store itself is not
// cleared and needs no sweep.
module bounded_array_list_engine_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bale_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_ready,
  output bale_pkg::rsp_t out_rsp
);

  bale_pkg::state_t                  state_r, state_nxt;
  logic [bale_pkg::CNT_W-1:0]        scan_r, scan_nxt;
  logic [bale_pkg::ADDR_W-1:0]       cmp_r, cmp_nxt;
  logic                              pend_r, pend_nxt;
  logic [bale_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [bale_pkg::WORD_W-1:0]       value_r, value_nxt;
  logic                              frm_r, frm_nxt;
  bale_pkg::rsp_t                    res_r, res_nxt;
  bale_pkg::rsp_t                    out_r, out_nxt;
  logic                              out_valid_r, out_valid_nxt;

  logic                              mem_we;
  logic [bale_pkg::ADDR_W-1:0]       mem_waddr;
  logic [bale_pkg::WORD_W-1:0]       mem_wdata;
  logic                              mem_re;
  logic [bale_pkg::ADDR_W-1:0]       mem_raddr;
  logic [bale_pkg::WORD_W-1:0]       mem_rdata;

  logic                              out_free;
  logic                              fin;
  logic                              fin_status;
  logic [bale_pkg::POS_W-1:0]        fin_pos;
  bale_pkg::rsp_t                    fin_rsp;
  logic [bale_pkg::CNT_W-1:0]        scan_dec;
  logic [bale_pkg::CNT_W-1:0]        cnt_dec;
  logic [bale_pkg::CNT_W-1:0]        cmp_ext;
  logic                              idx_ok;
  logic                              hit;

  bale_ram #(
    .WIDTH(bale_pkg::WORD_W),
    .DEPTH(bale_pkg::CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign in_ready  = (state_r == bale_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign scan_dec = scan_r - bale_pkg::CNT_W'(1);
  assign cnt_dec  = cnt_r - bale_pkg::CNT_W'(1);
  assign cmp_ext  = bale_pkg::CNT_W'(cmp_r);
  assign idx_ok   = bale_pkg::WIDE_W'(in_req.index) < bale_pkg::WIDE_W'(cnt_r);
  assign hit      = pend_r && (mem_rdata == value_r);

  // Next state, store access and result
  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    cmp_nxt       = cmp_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    value_nxt     = value_r;
    frm_nxt       = frm_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[bale_pkg::ADDR_W-1:0];
    mem_wdata     = in_req.value;
    mem_re        = 1'b0;
    mem_raddr     = scan_r[bale_pkg::ADDR_W-1:0];
    fin           = 1'b0;
    fin_status    = 1'b1;
    fin_pos       = '0;

    unique case (state_r)
      bale_pkg::S_IDLE: begin
        if (in_valid) begin
          value_nxt = in_req.value;
          frm_nxt   = (in_req.func == bale_pkg::FN_FIND_REMOVE);
          unique case (in_req.func) inside
            bale_pkg::FN_CLEAR: begin
              cnt_nxt    = '0;
              fin        = 1'b1;
              fin_status = 1'b0;
            end
            bale_pkg::FN_APPEND: begin
              fin = 1'b1;
              if (cnt_r < bale_pkg::CNT_W'(bale_pkg::CAPACITY)) begin
                mem_we     = 1'b1;
                cnt_nxt    = cnt_r + bale_pkg::CNT_W'(1);
                fin_status = 1'b0;
              end
            end
            bale_pkg::FN_POP: begin
              fin = 1'b1;
              if (cnt_r != '0) begin
                cnt_nxt    = cnt_dec;
                fin_status = 1'b0;
              end
            end
            bale_pkg::FN_REMOVE_AT: begin
              if (idx_ok) begin
                scan_nxt         = bale_pkg::CNT_W'(in_req.index) + bale_pkg::CNT_W'(1);
                pend_nxt         = 1'b0;
                res_nxt.position = '0;
                state_nxt        = bale_pkg::S_SHIFT;
              end else begin
                fin = 1'b1;
              end
            end
            bale_pkg::FN_SEARCH, bale_pkg::FN_FIND_REMOVE: begin
              if (cnt_r != '0) begin
                scan_nxt  = '0;
                pend_nxt  = 1'b0;
                state_nxt = bale_pkg::S_SEARCH;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // One read issued per cycle; data of the previous read compared
      bale_pkg::S_SEARCH: begin
        if (hit) begin
          if (frm_r) begin
            scan_nxt         = cmp_ext + bale_pkg::CNT_W'(1);
            pend_nxt         = 1'b0;
            res_nxt.position = bale_pkg::POS_W'(cmp_r);
            state_nxt        = bale_pkg::S_SHIFT;
          end else begin
            pend_nxt   = 1'b0;
            fin        = 1'b1;
            fin_status = 1'b0;
            fin_pos    = bale_pkg::POS_W'(cmp_r);
          end
        end else if (pend_r && (cmp_ext == cnt_dec)) begin
          pend_nxt = 1'b0;
          fin      = 1'b1;
        end else begin
          mem_re   = 1'b1;
          cmp_nxt  = scan_r[bale_pkg::ADDR_W-1:0];
          pend_nxt = 1'b1;
          scan_nxt = scan_r + bale_pkg::CNT_W'(1);
        end
      end

      // Read slot j+1, write its word into slot j in the next cycle
      bale_pkg::S_SHIFT: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_r;
          mem_wdata = mem_rdata;
        end
        if (scan_r == cnt_r) begin
          cnt_nxt    = cnt_dec;
          pend_nxt   = 1'b0;
          fin        = 1'b1;
          fin_status = 1'b0;
          fin_pos    = res_r.position;
        end else begin
          mem_re   = 1'b1;
          cmp_nxt  = scan_dec[bale_pkg::ADDR_W-1:0];
          pend_nxt = 1'b1;
          scan_nxt = scan_r + bale_pkg::CNT_W'(1);
        end
      end

      bale_pkg::S_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = bale_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bale_pkg::S_IDLE;
      end
    endcase

    // Hand the result to the output register, or park it
    fin_rsp = '{status: fin_status, position: fin_pos,
                count: bale_pkg::OCNT_W'(cnt_nxt)};
    if (fin) begin
      if (out_free) begin
        out_nxt       = fin_rsp;
        out_valid_nxt = 1'b1;
        state_nxt     = bale_pkg::S_IDLE;
      end else begin
        res_nxt   = fin_rsp;
        state_nxt = bale_pkg::S_DONE;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bale_pkg::S_IDLE;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    scan_r  <= scan_nxt;
    cmp_r   <= cmp_nxt;
    value_r <= value_nxt;
    frm_r   <= frm_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  // Live count never exceeds the store
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bale_pkg::CNT_W'(bale_pkg::CAPACITY))
    else $error("live count above capacity");

  // Reads only touch live entries
  a_read_live: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (bale_pkg::CNT_W'(mem_raddr) < cnt_r))
    else $error("read beyond live entries");

  // A shift write lands below the last live slot
  a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (state_r == bale_pkg::S_SHIFT)) |->
      (bale_pkg::CNT_W'(mem_waddr) < cnt_dec))
    else $error("shift write out of range");

  // Search never runs on an empty list
  a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bale_pkg::S_SEARCH) |-> (cnt_r != '0))
    else $error("search with empty list");

  // A compare pending in search refers to a live entry
  a_pend_live: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && (state_r == bale_pkg::S_SEARCH)) |-> (cmp_ext < cnt_r))
    else $error("pending compare beyond live entries");

endmodule

@@ src/bale_ram.sv @@
module bale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
